@@ design/sps_pkg.sv @@
package sps_pkg;

   // storage depths
   localparam int RX_DEPTH = 2;
   localparam int TX_DEPTH = 8;

   localparam int RX_IDX_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   // field widths
   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int SEL_W    = 2;
   localparam int ID_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_SENSORS = 3;

   // bus event codes
   typedef enum logic [OP_W-1:0] {
      OP_RX_BYTE  = 2'd0,
      OP_TX_READY = 2'd1,
      OP_END      = 2'd2,
      OP_SENSOR   = 2'd3
   } op_type;

   // sensor selects
   typedef enum logic [SEL_W-1:0] {
      SENSOR_BUTTON = 2'd0,
      SENSOR_DOOR   = 2'd1,
      SENSOR_POOL   = 2'd2
   } sensor_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUTTON_ID = 2'd0,
      CSR_DOOR_ID   = 2'd1,
      CSR_POOL_ID   = 2'd2
   } csr_type;

endpackage

@@ design/sps_req_if.sv @@
interface sps_req_if;
   logic                           valid;
   logic                           ready;
   logic [sps_pkg::OP_W-1:0]       op;
   logic [sps_pkg::BYTE_W-1:0]     data;
   logic [sps_pkg::SEL_W-1:0]      sensor_sel;

   modport source(output valid, op, data, sensor_sel, input ready);
   modport sink(input valid, op, data, sensor_sel, output ready);
endinterface

@@ design/sps_rsp_if.sv @@
interface sps_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sps_pkg::BYTE_W-1:0]     tx_byte;

   modport source(output valid, tx_byte, input ready);
   modport sink(input valid, tx_byte, output ready);
endinterface

@@ design/i2c_slave_sensor_poll_responder_unit.sv @@
// Sensor poll responder, slave side of a two-wire bus. Each req word is one bus event:
// a received byte, a transmit-ready request, the end of an access or a sensor update.
// At the end of a write access the first two received bytes are matched against the
// button, door and pool IDs and a seven-byte reply is built (ID bytes, sensor value,
// three zero bytes, XOR check byte; old body bytes stay on no match); its first byte is
// returned straight away, and each transmit-ready event returns the next byte. Events
// are handled by the logic in front of the state registers, so one word is taken per
// clock unless rsp stalls; a result word appears on rsp in the cycle after its event is
// taken and sits in a single output register, passed on while the next event is accepted.
module i2c_slave_sensor_poll_responder_unit (
   input  logic                              clock,
   input  logic                              reset,
   sps_req_if.sink                           req_chan,
   sps_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sps_pkg::ID_W-1:0]          csr_wdata
);

   localparam int RXW = sps_pkg::RX_IDX_W;
   localparam int TXW = sps_pkg::TX_IDX_W;
   localparam int BW  = sps_pkg::BYTE_W;

   // configuration registers
   logic [sps_pkg::ID_W-1:0] button_id_ff, door_id_ff, pool_id_ff;

   // state
   logic [BW-1:0]  rx_store_ff [sps_pkg::RX_DEPTH];
   logic [BW-1:0]  rx_store_in [sps_pkg::RX_DEPTH];
   logic [RXW-1:0] rx_index_ff, rx_index_in;
   logic [BW-1:0]  tx_store_ff [sps_pkg::TX_DEPTH];
   logic [BW-1:0]  tx_store_in [sps_pkg::TX_DEPTH];
   logic [TXW-1:0] tx_index_ff, tx_index_in;
   logic           got_write_ff, got_write_in;
   logic           got_read_ff, got_read_in;
   logic [BW-1:0]  sensor_ff [sps_pkg::NUM_SENSORS];
   logic [BW-1:0]  sensor_in [sps_pkg::NUM_SENSORS];

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]  rsp_byte_ff, rsp_byte_in;

   logic           accept;
   logic [sps_pkg::NUM_SENSORS-1:0] id_match;
   logic [BW-1:0]  reply_b2, reply_b3, reply_b4, reply_b5, reply_check;

   // handshake
   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.tx_byte = rsp_byte_ff;

   // id compare against the first two received bytes
   assign id_match[0] = (rx_store_ff[0] == button_id_ff[15:8]) &&
                        (rx_store_ff[1] == button_id_ff[7:0]);
   assign id_match[1] = (rx_store_ff[0] == door_id_ff[15:8]) &&
                        (rx_store_ff[1] == door_id_ff[7:0]);
   assign id_match[2] = (rx_store_ff[0] == pool_id_ff[15:8]) &&
                        (rx_store_ff[1] == pool_id_ff[7:0]);

   // reply body, last matched sensor wins, old bytes kept on no match
   always_comb begin
      reply_b2 = tx_store_ff[2];
      reply_b3 = tx_store_ff[3];
      reply_b4 = tx_store_ff[4];
      reply_b5 = tx_store_ff[5];
      if (id_match != '0) begin
         reply_b3 = '0;
         reply_b4 = '0;
         reply_b5 = '0;
         if (id_match[2]) begin
            reply_b2 = sensor_ff[2];
         end else if (id_match[1]) begin
            reply_b2 = sensor_ff[1];
         end else begin
            reply_b2 = sensor_ff[0];
         end
      end
      reply_check = rx_store_ff[0] ^ rx_store_ff[1] ^ reply_b2 ^
                    reply_b3 ^ reply_b4 ^ reply_b5;
   end

   // event handling
   always_comb begin
      rx_store_in  = rx_store_ff;
      rx_index_in  = rx_index_ff;
      tx_store_in  = tx_store_ff;
      tx_index_in  = tx_index_ff;
      got_write_in = got_write_ff;
      got_read_in  = got_read_ff;
      sensor_in    = sensor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      if (accept) begin
         case (req_chan.op)
            sps_pkg::OP_RX_BYTE: begin
               got_write_in = 1'b1;
               rx_store_in[rx_index_ff] = req_chan.data;
               if (rx_index_ff == RXW'(sps_pkg::RX_DEPTH - 1)) begin
                  rx_index_in = '0;
               end else begin
                  rx_index_in = rx_index_ff + RXW'(1);
               end
            end
            sps_pkg::OP_TX_READY: begin
               got_read_in  = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = tx_store_ff[tx_index_ff];
               if (tx_index_ff == TXW'(sps_pkg::TX_DEPTH - 1)) begin
                  tx_index_in = '0;
               end else begin
                  tx_index_in = tx_index_ff + TXW'(1);
               end
            end
            sps_pkg::OP_END: begin
               if (got_write_ff) begin
                  got_write_in   = 1'b0;
                  rx_index_in    = '0;
                  tx_store_in[0] = rx_store_ff[0];
                  tx_store_in[1] = rx_store_ff[1];
                  tx_store_in[2] = reply_b2;
                  tx_store_in[3] = reply_b3;
                  tx_store_in[4] = reply_b4;
                  tx_store_in[5] = reply_b5;
                  tx_store_in[6] = reply_check;
                  for (int s = 0; s < sps_pkg::NUM_SENSORS; s++) begin
                     if (id_match[s]) begin
                        sensor_in[s] = '0;
                     end
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_byte_in    = rx_store_ff[0];
                  tx_index_in    = TXW'(1);
                  rx_store_in[0] = '0;
                  rx_store_in[1] = '0;
               end else if (got_read_ff) begin
                  got_read_in = 1'b0;
                  tx_index_in = '0;
                  rx_index_in = '0;
               end
            end
            sps_pkg::OP_SENSOR: begin
               case (req_chan.sensor_sel)
                  sps_pkg::SENSOR_BUTTON: sensor_in[0] = req_chan.data;
                  sps_pkg::SENSOR_DOOR:   sensor_in[1] = req_chan.data;
                  sps_pkg::SENSOR_POOL:   sensor_in[2] = req_chan.data;
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         button_id_ff <= '0;
         door_id_ff   <= '0;
         pool_id_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sps_pkg::CSR_BUTTON_ID: button_id_ff <= csr_wdata;
            sps_pkg::CSR_DOOR_ID:   door_id_ff   <= csr_wdata;
            sps_pkg::CSR_POOL_ID:   pool_id_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sps_pkg::RX_DEPTH; i++) begin
            rx_store_ff[i] <= '0;
         end
         for (int i = 0; i < sps_pkg::TX_DEPTH; i++) begin
            tx_store_ff[i] <= '0;
         end
         for (int i = 0; i < sps_pkg::NUM_SENSORS; i++) begin
            sensor_ff[i] <= '0;
         end
         rx_index_ff  <= '0;
         tx_index_ff  <= '0;
         got_write_ff <= 1'b0;
         got_read_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_store_ff  <= rx_store_in;
         tx_store_ff  <= tx_store_in;
         sensor_ff    <= sensor_in;
         rx_index_ff  <= rx_index_in;
         tx_index_ff  <= tx_index_in;
         got_write_ff <= got_write_in;
         got_read_ff  <= got_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule

@@ test/i2c_slave_sensor_poll_responder_unit_test.sv @@
`timescale 1ns / 100ps

module i2c_slave_sensor_poll_responder_unit_test;
   import sps_pkg::*;

   // sensor select that names no sensor
   localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;
   // long receiver hold-off used once to back the block up
   localparam int HOLD_CYCLES = 300;

   // predicts the tx bytes from the accepted bus events and keeps them in order
   class sps_scoreboard;
      logic [ID_W-1:0]   sensor_id [NUM_SENSORS];
      logic [BYTE_W-1:0] level [NUM_SENSORS];
      logic [BYTE_W-1:0] rx_bytes [RX_DEPTH];
      logic [BYTE_W-1:0] reply [TX_DEPTH];
      int                rx_ptr;
      int                tx_ptr;
      bit                write_seen;
      bit                read_seen;
      logic [BYTE_W-1:0] expected_bytes [$];

      function new();
         foreach (sensor_id[i]) sensor_id[i] = '0;
         foreach (level[i]) level[i] = '0;
         foreach (rx_bytes[i]) rx_bytes[i] = '0;
         foreach (reply[i]) reply[i] = '0;
         rx_ptr = 0;
         tx_ptr = 0;
         write_seen = 1'b0;
         read_seen = 1'b0;
      endfunction

      function void set_id(csr_type idx, logic [ID_W-1:0] v);
         case (idx)
            CSR_BUTTON_ID: sensor_id[SENSOR_BUTTON] = v;
            CSR_DOOR_ID:   sensor_id[SENSOR_DOOR] = v;
            CSR_POOL_ID:   sensor_id[SENSOR_POOL] = v;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void note_event(op_type op, logic [BYTE_W-1:0] data, logic [SEL_W-1:0] sel);
         int s;
         case (op)
            OP_RX_BYTE: begin
               rx_bytes[rx_ptr] = data;
               rx_ptr = (rx_ptr + 1) % RX_DEPTH;
               write_seen = 1'b1;
            end
            OP_TX_READY: begin
               expected_bytes.push_back(reply[tx_ptr]);
               tx_ptr = (tx_ptr + 1) % TX_DEPTH;
               read_seen = 1'b1;
            end
            OP_END: begin
               if (write_seen) begin
                  write_seen = 1'b0;
                  rx_ptr = 0;
                  // reply: id bytes, sensor level, zero bytes, xor check
                  reply[0] = rx_bytes[0];
                  reply[1] = rx_bytes[1];
                  for (s = 0; s < NUM_SENSORS; s++) begin
                     if ({rx_bytes[0], rx_bytes[1]} == sensor_id[s]) begin
                        reply[2] = level[s];
                        reply[3] = '0;
                        reply[4] = '0;
                        reply[5] = '0;
                        level[s] = '0;
                     end
                  end
                  reply[6] = reply[0] ^ reply[1] ^ reply[2] ^ reply[3] ^ reply[4] ^ reply[5];
                  expected_bytes.push_back(reply[0]);
                  tx_ptr = 1 % TX_DEPTH;
                  rx_bytes[0] = '0;
                  rx_bytes[1] = '0;
               end else if (read_seen) begin
                  read_seen = 1'b0;
                  tx_ptr = 0;
                  rx_ptr = 0;
               end
            end
            default: begin
               if (sel < NUM_SENSORS)
                  level[sel] = data;
            end
         endcase
      endfunction

      function bit check_word(logic [BYTE_W-1:0] got, output string why);
         logic [BYTE_W-1:0] want;
         why = "";
         if (expected_bytes.size() == 0) begin
            why = $sformatf("tx_byte %02h with no word expected", got);
            return 1'b0;
         end
         want = expected_bytes.pop_front();
         if (got !== want) begin
            why = $sformatf("tx_byte %02h, expected %02h", got, want);
            return 1'b0;
         end
         return 1'b1;
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ID_W-1:0]      csr_wdata;

   sps_req_if req_bus();
   sps_rsp_if rsp_bus();

   sps_scoreboard sb;
   int            errors = 0;
   int            words_sent = 0;
   bit            calm = 1'b0;
   bit            hold_req = 1'b0;
   string         why;

   i2c_slave_sensor_poll_responder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task report_mismatch(string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
   endtask

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offer one event word; entered and left at a falling edge
   task automatic send_event(op_type op, logic [BYTE_W-1:0] data, logic [SEL_W-1:0] sel);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.data       <= data;
      req_bus.sensor_sel <= sel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      if (!(op == OP_SENSOR && sel == SEL_NONE))
         words_sent++;
   endtask

   // write all three sensor ids, one per cycle
   task automatic load_ids(logic [ID_W-1:0] b, logic [ID_W-1:0] d, logic [ID_W-1:0] p);
      csr_we    <= 1'b1;
      csr_index <= CSR_BUTTON_ID;
      csr_wdata <= b;
      sb.set_id(CSR_BUTTON_ID, b);
      @(negedge clock);
      csr_index <= CSR_DOOR_ID;
      csr_wdata <= d;
      sb.set_id(CSR_DOOR_ID, d);
      @(negedge clock);
      csr_index <= CSR_POOL_ID;
      csr_wdata <= p;
      sb.set_id(CSR_POOL_ID, p);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stop offering and let every expected word and any silent event drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly complete poll transactions with random content, some noise
   task automatic run_phase(int n);
      int              stop_at;
      logic [ID_W-1:0] id;
      stop_at = words_sent + n;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 99) < 75) begin
            if ($urandom_range(0, 2) == 0)
               send_event(OP_SENSOR, BYTE_W'($urandom), SEL_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) != 0)
               id = sb.sensor_id[$urandom_range(0, NUM_SENSORS - 1)];
            else
               id = ID_W'($urandom);
            send_event(OP_RX_BYTE, id[15:8], SEL_W'($urandom_range(0, 3)));
            send_event(OP_RX_BYTE, id[7:0], SEL_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 3))
                  send_event(OP_RX_BYTE, BYTE_W'($urandom), SEL_W'($urandom_range(0, 3)));
            send_event(OP_END, BYTE_W'($urandom), SEL_W'($urandom_range(0, 3)));
            repeat ($urandom_range(0, 9))
               send_event(OP_TX_READY, BYTE_W'($urandom), SEL_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 5) != 0)
               send_event(OP_END, BYTE_W'($urandom), SEL_W'($urandom_range(0, 3)));
         end else begin
            repeat ($urandom_range(1, 4))
               send_event(op_type'($urandom_range(0, 3)), BYTE_W'($urandom),
                          SEL_W'($urandom_range(0, 3)));
         end
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      int hold_left;
      stall = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            if (!sb.check_word(rsp_bus.tx_byte, why))
               report_mismatch(why);
         if (req_bus.valid && req_bus.ready)
            sb.note_event(op_type'(req_bus.op), req_bus.data, req_bus.sensor_sel);
      end
   end

   // main sequence
   initial begin
      int              p;
      int              k;
      logic [ID_W-1:0] ids [NUM_SENSORS];
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_BUTTON_ID;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_RX_BYTE;
      req_bus.data       = '0;
      req_bus.sensor_sel = SENSOR_BUTTON;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // end with no access open, a read from the reset reply, end of read
      send_event(OP_END, 8'h00, SENSOR_BUTTON);
      send_event(OP_TX_READY, 8'hff, SENSOR_BUTTON);
      send_event(OP_END, 8'h00, SENSOR_BUTTON);
      settle();
      load_ids(16'ha55a, 16'h0000, 16'hffff);

      // sensor levels, including the select that names no sensor
      send_event(OP_SENSOR, 8'hff, SENSOR_BUTTON);
      send_event(OP_SENSOR, 8'h00, SENSOR_DOOR);
      send_event(OP_SENSOR, 8'h80, SENSOR_POOL);
      send_event(OP_SENSOR, 8'h5a, SEL_NONE);
      // button poll, then part of the reply read back
      send_event(OP_RX_BYTE, 8'ha5, SENSOR_BUTTON);
      send_event(OP_RX_BYTE, 8'h5a, SENSOR_BUTTON);
      send_event(OP_END, 8'h00, SENSOR_BUTTON);
      repeat (3) send_event(OP_TX_READY, 8'h00, SENSOR_BUTTON);
      send_event(OP_END, 8'h00, SENSOR_BUTTON);
      // receive index wraps, unknown id keeps the old reply body
      send_event(OP_RX_BYTE, 8'hff, SENSOR_BUTTON);
      send_event(OP_RX_BYTE, 8'hff, SENSOR_BUTTON);
      send_event(OP_RX_BYTE, 8'h12, SENSOR_BUTTON);
      send_event(OP_END, 8'h00, SENSOR_BUTTON);
      settle();

      // door and pool share an id: both cleared, pool level returned
      load_ids(16'h1234, 16'h00ff, 16'h00ff);
      send_event(OP_SENSOR, 8'hc3, SENSOR_POOL);
      send_event(OP_RX_BYTE, 8'h00, SENSOR_BUTTON);
      send_event(OP_RX_BYTE, 8'hff, SENSOR_BUTTON);
      send_event(OP_END, 8'h00, SENSOR_BUTTON);
      repeat (2) send_event(OP_TX_READY, 8'h00, SENSOR_BUTTON);
      send_event(OP_END, 8'h00, SENSOR_BUTTON);

      // random phases, each under its own id setting
      for (p = 0; p < 8; p++) begin
         settle();
         for (k = 0; k < NUM_SENSORS; k++) begin
            case (p)
               0: ids[k] = '0;
               1: ids[k] = '1;
               default: begin
                  if (k > 0 && $urandom_range(0, 3) == 0)
                     ids[k] = ids[k - 1];
                  else if ($urandom_range(0, 9) == 0)
                     ids[k] = ($urandom_range(0, 1) == 0) ? '0 : '1;
                  else
                     ids[k] = ID_W'($urandom);
               end
            endcase
         end
         load_ids(ids[0], ids[1], ids[2]);
         calm = (p == 4);
         if (p == 2)
            hold_req = 1'b1;
         run_phase(210);
      end

      settle();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("** i2c_slave_sensor_poll_responder_unit: PASSED **");
      else
         $display("** i2c_slave_sensor_poll_responder_unit: FAILED **");
      $finish;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("** i2c_slave_sensor_poll_responder_unit: FAILED **");
      $finish;
   end

endmodule

@@ sim.f @@
design/sps_pkg.sv
design/sps_req_if.sv
design/sps_rsp_if.sv
design/i2c_slave_sensor_poll_responder_unit.sv
test/i2c_slave_sensor_poll_responder_unit_test.sv
